// ===== rtl/rtd_code_to_temperature_top_assert.svh =====
// Assertion macros for the RTD code to temperature converter checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef RTD_CODE_TO_TEMPERATURE_TOP_ASSERT_SVH
`define RTD_CODE_TO_TEMPERATURE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define RTDC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RTDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rtdc_pkg.sv =====
// Shared widths, constants and payload types of the RTD code to temperature converter.
// No dependencies; every other file except the assertion header imports this package.
`default_nettype none

package rtdc_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int CODE_W    = 15;
    localparam int REF_W     = 10;
    localparam int TEMP_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = REF_W;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_FAHRENHEIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE  = 2'd1;
    localparam logic [REF_W-1:0]     REF_RESET      = 10'd385;

    // Default number of fraction bits of the temperature output
    localparam int DEF_TEMP_FRAC_BITS = 4;

    // Resistance and root-argument arithmetic
    localparam int PROD_W     = CODE_W + REF_W;     // code * reference ohms
    localparam int Z3_W       = 23;
    localparam int SCALED_W   = PROD_W + Z3_W;      // Z3 term
    localparam int Y_W        = 47;                 // clamped root argument
    localparam int RAD_SHIFT  = 16;
    localparam int V_W        = 64;                 // radicand, even width
    localparam logic [Z3_W-1:0]     Z3_SCALED  = 23'd4620000;
    localparam logic [SCALED_W-1:0] Z2_SHIFTED = SCALED_W'(64'd1758480889 * 64'd65536);

    // Square root
    localparam int ROOT_W               = V_W / 2;
    localparam int REM_W                = ROOT_W + 1;
    localparam int SQRT_STEPS_PER_STAGE = 2;
    localparam int SQRT_STAGES          = ROOT_W / SQRT_STEPS_PER_STAGE;

    // Final scaling: numerator offset and denominator 231 * 2^15
    localparam int MAG_W     = ROOT_W;
    localparam int DEN_SHIFT = 15;
    localparam int DEN_ODD   = 231;
    localparam logic [ROOT_W-1:0] Z1_SHIFTED = 32'd2561343488;
    localparam logic [23:0]       HALF_DEN   = 24'(DEN_ODD << (DEN_SHIFT - 1));

    // Pipeline depth per section
    localparam int FRONT_STAGES = 3;
    localparam int SCALE_STAGES = 6;
    localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_STAGES + SCALE_STAGES;

    // Front end to square root
    typedef struct packed {
        logic           fault;
        logic [V_W-1:0] radicand;
    } root_arg_t;

    // Square root to scaling
    typedef struct packed {
        logic              fault;
        logic [ROOT_W-1:0] root;
    } root_t;

    // Final result
    typedef struct packed {
        logic [TEMP_W-1:0] temperature_value;
        logic              fault_flag;
    } temp_result_t;

endpackage

`default_nettype wire

// ===== rtl/rtdc_if.sv =====
// Valid/ready channel interfaces for readings and results.
// Depends on rtdc_pkg for field widths.
`default_nettype none

interface rtdc_in_if
    import rtdc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rtd_high_byte;
    logic [BYTE_W-1:0] rtd_low_byte;

    modport source (output valid, output rtd_high_byte, output rtd_low_byte, input ready);
    modport sink   (input valid, input rtd_high_byte, input rtd_low_byte, output ready);
endinterface

interface rtdc_out_if
    import rtdc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature_value;
    logic                     fault_flag;

    modport source (output valid, output temperature_value, output fault_flag, input ready);
    modport sink   (input valid, input temperature_value, input fault_flag, output ready);
endinterface

`default_nettype wire

// ===== rtl/rtdc_front.sv =====
// Front end: code assembly, resistance product, root argument and clamp (three stages).
// Depends on rtdc_pkg.
`default_nettype none

module rtdc_front
    import rtdc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [REF_W-1:0]  reference_ohms,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] rtd_high_byte,
    input  wire logic [BYTE_W-1:0] rtd_low_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output root_arg_t              out_data
);

    logic [FRONT_STAGES-1:0] valid_reg;
    logic [FRONT_STAGES-1:0] adv;

    logic [FRONT_STAGES-1:0] fault_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [SCALED_W-1:0]     scaled_reg;
    logic [V_W-1:0]          radicand_reg;

    logic [CODE_W-1:0]       code;
    logic [PROD_W-1:0]       prod_next;
    logic [SCALED_W-1:0]     scaled_next;
    logic [Y_W-1:0]          y_next;
    logic [V_W-1:0]          radicand_next;

    // Advance a stage when it is empty or the one below moves
    always_comb
    begin
        adv[FRONT_STAGES-1] = !valid_reg[FRONT_STAGES-1] || out_ready;
        for (int i = FRONT_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[FRONT_STAGES-1];

    // Stage datapath
    always_comb
    begin
        code          = {rtd_high_byte, rtd_low_byte[BYTE_W-1:1]};
        prod_next     = PROD_W'(code) * PROD_W'(reference_ohms);
        scaled_next   = SCALED_W'(prod_reg) * SCALED_W'(Z3_SCALED);
        // Clamp a negative root argument to zero
        if (scaled_reg > Z2_SHIFTED)
        begin
            y_next = '0;
        end
        else
        begin
            y_next = Y_W'(Z2_SHIFTED - scaled_reg);
        end
        radicand_next = V_W'({y_next, {RAD_SHIFT{1'b0}}});
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < FRONT_STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            fault_reg[0] <= rtd_low_byte[0];
            prod_reg     <= prod_next;
        end
        if (adv[1])
        begin
            fault_reg[1] <= fault_reg[0];
            scaled_reg   <= scaled_next;
        end
        if (adv[2])
        begin
            fault_reg[2] <= fault_reg[1];
            radicand_reg <= radicand_next;
        end
    end

    assign out_data.fault    = fault_reg[FRONT_STAGES-1];
    assign out_data.radicand = radicand_reg;

endmodule

`default_nettype wire

// ===== rtl/rtdc_sqrt.sv =====
// Pipelined restoring integer square root, two root bits per stage.
// Depends on rtdc_pkg.
`default_nettype none

module rtdc_sqrt
    import rtdc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire root_arg_t in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output root_t          out_data
);

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [V_W-1:0]    rad;
    } sqrt_state_t;

    // Take the next radicand bit pairs, one root bit each
    function automatic sqrt_state_t sqrt_stage(input sqrt_state_t s);
        sqrt_state_t      st;
        logic [REM_W+1:0] work;
        logic [REM_W+1:0] trial;
        st = s;
        for (int k = 0; k < SQRT_STEPS_PER_STAGE; k++)
        begin
            work  = {st.rem, st.rad[V_W-1 -: 2]};
            trial = (REM_W + 2)'({st.root, 2'b01});
            if (work >= trial)
            begin
                st.rem  = REM_W'(work - trial);
                st.root = {st.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                st.rem  = REM_W'(work);
                st.root = {st.root[ROOT_W-2:0], 1'b0};
            end
            st.rad = {st.rad[V_W-3:0], 2'b00};
        end
        return st;
    endfunction

    logic [SQRT_STAGES-1:0] valid_reg;
    logic [SQRT_STAGES-1:0] adv;
    logic [SQRT_STAGES-1:0] fault_reg;
    sqrt_state_t            state_reg [SQRT_STAGES];
    sqrt_state_t            stage_in  [SQRT_STAGES];
    sqrt_state_t            stage_out [SQRT_STAGES];

    // Advance a stage when it is empty or the one below moves
    always_comb
    begin
        adv[SQRT_STAGES-1] = !valid_reg[SQRT_STAGES-1] || out_ready;
        for (int i = SQRT_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[SQRT_STAGES-1];

    // Per-stage step logic
    assign stage_in[0] = '{rem: '0, root: '0, rad: in_data.radicand};
    genvar g;
    generate
        for (g = 1; g < SQRT_STAGES; g++)
        begin : g_link
            assign stage_in[g] = state_reg[g-1];
        end
        for (g = 0; g < SQRT_STAGES; g++)
        begin : g_step
            assign stage_out[g] = sqrt_stage(stage_in[g]);
        end
    endgenerate

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < SQRT_STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            fault_reg[0] <= in_data.fault;
            state_reg[0] <= stage_out[0];
        end
        for (int i = 1; i < SQRT_STAGES; i++)
        begin
            if (adv[i])
            begin
                fault_reg[i] <= fault_reg[i-1];
                state_reg[i] <= stage_out[i];
            end
        end
    end

    assign out_data.fault = fault_reg[SQRT_STAGES-1];
    assign out_data.root  = state_reg[SQRT_STAGES-1].root;

endmodule

`default_nettype wire

// ===== rtl/rtdc_scale.sv =====
// Scaling back end: numerator, rounded division by the constant denominator,
// Fahrenheit offset and saturation (six stages). Depends on rtdc_pkg.
`default_nettype none

module rtdc_scale
    import rtdc_pkg::*;
#(
    parameter int TEMP_FRAC_BITS = DEF_TEMP_FRAC_BITS
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fahrenheit_mode,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire root_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output temp_result_t out_data
);

    // Widths that follow from the number of fraction bits
    localparam int K_W    = 5 + TEMP_FRAC_BITS;
    localparam int PK_W   = MAG_W + K_W;
    localparam int M_W    = PK_W + 1;
    localparam int X_W    = M_W - DEN_SHIFT;
    localparam int RSHIFT = X_W + 8;
    localparam int R_W    = RSHIFT - 7;
    localparam int Q_W    = X_W - 7;
    localparam int E_W    = X_W + R_W;
    localparam int SW     = Q_W + 2;

    localparam logic [K_W-1:0] K_CELSIUS    = K_W'(10 << TEMP_FRAC_BITS);
    localparam logic [K_W-1:0] K_FAHRENHEIT = K_W'(18 << TEMP_FRAC_BITS);
    localparam logic [63:0]    RECIP_FULL   = (64'd1 << RSHIFT) / 64'(DEN_ODD);
    localparam logic [R_W-1:0] RECIP        = RECIP_FULL[R_W-1:0];
    localparam logic [X_W-1:0] DEN_ODD_X    = X_W'(DEN_ODD);

    localparam logic signed [SW-1:0] FAHR_OFFSET = SW'(32 << TEMP_FRAC_BITS);
    localparam logic signed [SW-1:0] TEMP_HI     = SW'((2 ** (TEMP_W - 1)) - 1);
    localparam logic signed [SW-1:0] TEMP_LO     = SW'(-(2 ** (TEMP_W - 1)));

    logic [SCALE_STAGES-1:0] valid_reg;
    logic [SCALE_STAGES-1:0] adv;
    logic [SCALE_STAGES-2:0] fault_reg;
    logic [SCALE_STAGES-2:0] neg_reg;

    logic [MAG_W-1:0]   mag_reg;
    logic [PK_W-1:0]    pk_reg;
    logic [X_W-1:0]     x2_reg;
    logic [X_W-1:0]     x3_reg;
    logic [Q_W-1:0]     est_reg;
    logic [Q_W-1:0]     qmag_reg;
    temp_result_t       result_reg;

    logic [ROOT_W:0]    n_next;
    logic [MAG_W-1:0]   mag_next;
    logic [K_W-1:0]     k_sel;
    logic [PK_W-1:0]    pk_next;
    logic [M_W-1:0]     m_sum;
    logic [E_W-1:0]     est_full;
    logic [X_W-1:0]     prod_odd;
    logic [X_W-1:0]     rem_odd;
    logic [Q_W-1:0]     qmag_next;
    logic signed [SW-1:0] q_signed;
    logic signed [SW-1:0] q_sum;
    temp_result_t       result_next;

    // Advance a stage when it is empty or the one below moves
    always_comb
    begin
        adv[SCALE_STAGES-1] = !valid_reg[SCALE_STAGES-1] || out_ready;
        for (int i = SCALE_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[SCALE_STAGES-1];

    // Stage datapath
    always_comb
    begin
        // Numerator sign and magnitude
        n_next   = {1'b0, Z1_SHIFTED} - {1'b0, in_data.root};
        mag_next = n_next[ROOT_W] ? MAG_W'(~n_next + 1'b1) : MAG_W'(n_next);

        // Scale by 10 or 18 times 2^frac
        k_sel   = fahrenheit_mode ? K_FAHRENHEIT : K_CELSIUS;
        pk_next = PK_W'(mag_reg) * PK_W'(k_sel);

        // Round half up on the magnitude, drop the power-of-two part of the divisor
        m_sum = M_W'(pk_reg) + M_W'(HALF_DEN);

        // Reciprocal estimate of x / 231, low by at most one
        est_full = E_W'(x2_reg) * E_W'(RECIP);

        // Correct the estimate
        prod_odd  = X_W'(est_reg) * DEN_ODD_X;
        rem_odd   = x3_reg - prod_odd;
        qmag_next = (rem_odd >= DEN_ODD_X) ? Q_W'(est_reg + 1'b1) : est_reg;

        // Restore sign, add the Fahrenheit offset, saturate
        q_signed = neg_reg[4] ? -$signed(SW'(qmag_reg)) : $signed(SW'(qmag_reg));
        q_sum    = q_signed + (fahrenheit_mode ? FAHR_OFFSET : SW'(0));
        result_next.fault_flag = fault_reg[4];
        if (fault_reg[4])
        begin
            result_next.temperature_value = '0;
        end
        else if (q_sum > TEMP_HI)
        begin
            result_next.temperature_value = TEMP_HI[TEMP_W-1:0];
        end
        else if (q_sum < TEMP_LO)
        begin
            result_next.temperature_value = TEMP_LO[TEMP_W-1:0];
        end
        else
        begin
            result_next.temperature_value = q_sum[TEMP_W-1:0];
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < SCALE_STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            fault_reg[0] <= in_data.fault;
            neg_reg[0]   <= n_next[ROOT_W];
            mag_reg      <= mag_next;
        end
        if (adv[1])
        begin
            fault_reg[1] <= fault_reg[0];
            neg_reg[1]   <= neg_reg[0];
            pk_reg       <= pk_next;
        end
        if (adv[2])
        begin
            fault_reg[2] <= fault_reg[1];
            neg_reg[2]   <= neg_reg[1];
            x2_reg       <= m_sum[M_W-1:DEN_SHIFT];
        end
        if (adv[3])
        begin
            fault_reg[3] <= fault_reg[2];
            neg_reg[3]   <= neg_reg[2];
            x3_reg       <= x2_reg;
            est_reg      <= est_full[RSHIFT +: Q_W];
        end
        if (adv[4])
        begin
            fault_reg[4] <= fault_reg[3];
            neg_reg[4]   <= neg_reg[3];
            qmag_reg     <= qmag_next;
        end
        if (adv[5])
        begin
            result_reg <= result_next;
        end
    end

    assign out_data = result_reg;

endmodule

`default_nettype wire

// ===== rtl/rtd_code_to_temperature_top.sv =====
// RTD code to temperature converter (Pt100), top level.
// Reading channel in, result channel out, configuration write port.
// Pipeline: 3 front-end stages, 16 square-root stages, 6 scaling stages.
// Throughput: one reading per cycle while the result is not stalled;
// every stage has its own valid bit and advances when it is empty or
// the stage below moves.
// The 16-stage square root, two root bits per stage, sets the depth.
// A fault bit in the low byte gives fault_flag 1 and temperature 0.
// Output is signed, in units of 2^-TEMP_FRAC_BITS degree, saturated.
// Configuration: index 0 selects Fahrenheit, index 1 sets the reference
// resistor in ohms; other indexes are ignored. Write only while idle.
// Reset clears all valid bits and loads Celsius and 385 ohms.
// A stalled result holds in the output register; empty stages further up
// keep taking readings until the pipeline is full, then ready drops.
// Depends on rtdc_pkg, rtdc_if, rtdc_front, rtdc_sqrt and rtdc_scale.
`default_nettype none

module rtd_code_to_temperature_top
    import rtdc_pkg::*;
#(
    parameter int TEMP_FRAC_BITS = DEF_TEMP_FRAC_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write_enable,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    rtdc_in_if.sink                   reading,
    rtdc_out_if.source                result
);

    logic              fahrenheit_mode_reg;
    logic [REF_W-1:0]  reference_ohms_reg;

    logic              front_valid;
    logic              front_ready;
    root_arg_t         front_data;
    logic              sqrt_valid;
    logic              sqrt_ready;
    root_t             sqrt_data;
    temp_result_t      result_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fahrenheit_mode_reg <= 1'b0;
            reference_ohms_reg  <= REF_RESET;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_FAHRENHEIT: fahrenheit_mode_reg <= cfg_data[0];
                CFG_REFERENCE:  reference_ohms_reg  <= cfg_data[REF_W-1:0];
                default:        ;
            endcase
        end
    end

    // Code, resistance and root argument
    rtdc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .reference_ohms (reference_ohms_reg),
        .in_valid       (reading.valid),
        .in_ready       (reading.ready),
        .rtd_high_byte  (reading.rtd_high_byte),
        .rtd_low_byte   (reading.rtd_low_byte),
        .out_valid      (front_valid),
        .out_ready      (front_ready),
        .out_data       (front_data)
    );

    // Square root
    rtdc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (sqrt_valid),
        .out_ready (sqrt_ready),
        .out_data  (sqrt_data)
    );

    // Scaling, rounding and saturation
    rtdc_scale #(
        .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
    ) u_scale (
        .clk             (clk),
        .rst_n           (rst_n),
        .fahrenheit_mode (fahrenheit_mode_reg),
        .in_valid        (sqrt_valid),
        .in_ready        (sqrt_ready),
        .in_data         (sqrt_data),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_data        (result_data)
    );

    assign result.temperature_value = result_data.temperature_value;
    assign result.fault_flag        = result_data.fault_flag;

endmodule

`default_nettype wire

// ===== rtl/rtdc_checker.sv =====
// Port-level checker for the RTD code to temperature converter, bound to the top level.
// Depends on rtdc_pkg and rtd_code_to_temperature_top_assert.svh.
`default_nettype none

`include "rtd_code_to_temperature_top_assert.svh"

module rtdc_checker
    import rtdc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [TEMP_W-1:0] temperature_value,
    input wire logic              fault_flag
);

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] outstanding_reg;
    logic [CNT_W-1:0] outstanding_next;

    // Count transactions taken in but not yet delivered
    assign outstanding_next = CNT_W'(outstanding_reg + CNT_W'(in_valid && in_ready)
                                     - CNT_W'(out_valid && out_ready));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    `RTDC_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(temperature_value) && $stable(fault_flag), "stalled result changed")
    `RTDC_ASSERT_IMPLY(a_fault_zero, out_valid && fault_flag, temperature_value == '0, "fault result with nonzero temperature")
    `RTDC_ASSERT_IMPLY(a_no_phantom, out_valid, outstanding_reg != '0, "result without an accepted reading")
    `RTDC_ASSERT_IMPLY(a_empty_ready, !out_valid, in_ready, "input stalled while output stage empty")

endmodule

bind rtd_code_to_temperature_top rtdc_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (reading.valid),
    .in_ready          (reading.ready),
    .out_valid         (result.valid),
    .out_ready         (result.ready),
    .temperature_value (result.temperature_value),
    .fault_flag        (result.fault_flag)
);

`default_nettype wire
